// ----- rtl/core/ppm_fd_pkg.sv -----
// ppm_fd_pkg: shared types and constants of the ppm frame decoder
// no dependencies; used by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package ppm_fd_pkg;

  // fixed field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DeltaW  = 16;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  // register reset values
  localparam logic [DeltaW-1:0] SyncGapMinRst = 16'd2200;
  localparam logic [DeltaW-1:0] PulseMinRst   = 16'd950;
  localparam logic [DeltaW-1:0] PulseMaxRst   = 16'd2050;
  localparam logic [ChanW-1:0]  ChanCountRst  = 4'd8;

  // register map, word index within the apb window
  typedef enum logic [1:0] {
    REG_SYNC_GAP_MIN = 2'd0,
    REG_PULSE_MIN    = 2'd1,
    REG_PULSE_MAX    = 2'd2,
    REG_CHAN_COUNT   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DeltaW-1:0] sync_gap_min;
    logic [DeltaW-1:0] pulse_min;
    logic [DeltaW-1:0] pulse_max;
    logic [ChanW-1:0]  channel_count;
  } cfg_t;

  // frame decoder to burst emitter
  typedef struct packed {
    logic             start;
    logic             link_good;
    logic [ChanW-1:0] len;
  } burst_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppm_frame_decoder.sv -----
// ppm_frame_decoder: top level of the rc ppm pulse-train decoder
// depends on ppm_fd_pkg, ppm_fd_regs, ppm_fd_frame and ppm_fd_emit
`timescale 1ns / 1ps
`default_nettype none

// Decodes an rc ppm pulse train, one edge transaction at a time. Each input
// transaction carries the edge timestamp in microseconds and a flag saying
// whether it came from the ppm pin; non-pin transactions are dropped without
// touching any state. The interval to the previous pin edge is taken modulo
// 2^16: a gap of at least sync_gap_min arms the decoder and restarts the
// channel index, an armed interval inside [pulse_min, pulse_max] is stored as
// the next channel, and anything else disarms. Once channel_count channels
// (capped at MAX_CHANNELS, zero acting as one) are stored, the whole frame
// leaves as a burst of output transactions, channel 0 first, with last set on
// the final one and link_good showing whether a sync gap was seen while armed.
// Throughput: one input transaction per clock. While a burst drains, the
// emitter's snapshot buffer lets new edges be decoded; only an edge that
// completes another frame before the previous burst has drained waits in the
// input register. The first result of a burst passes the input register, the
// snapshot buffer and output register. Registers sit at byte addresses 0, 4, 8
// and 12 of the apb window; the user must write them only while the decoder is
// idle, which the block does not enforce. The channel store holds no reset.
module ppm_frame_decoder #(
  parameter int unsigned MAX_CHANNELS = 10
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // edge input
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [31:0]                      edge_time_us_i,
  input  wire                              from_ppm_pin_i,
  // channel output
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [3:0]                       channel_index_o,
  output logic [15:0]                      pulse_width_us_o,
  output logic                             link_good_o,
  output logic                             last_o,
  // configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [3:0]                       paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ppm_fd_pkg::cfg_t                                 cfg;
  ppm_fd_pkg::burst_ctl_t                           burst_ctl;
  logic [MAX_CHANNELS-1:0][ppm_fd_pkg::DeltaW-1:0]  snap;
  logic                                             emit_idle;

  // apb register file
  ppm_fd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // interval classification, decoder state and channel store
  ppm_fd_frame #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .edge_time_us_i (edge_time_us_i),
    .from_ppm_pin_i (from_ppm_pin_i),
    .cfg_i          (cfg),
    .emit_idle_i    (emit_idle),
    .ctl_o          (burst_ctl),
    .snap_o         (snap)
  );

  // burst snapshot and output register
  ppm_fd_emit #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (burst_ctl),
    .snap_i           (snap),
    .idle_o           (emit_idle),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_index_o  (channel_index_o),
    .pulse_width_us_o (pulse_width_us_o),
    .link_good_o      (link_good_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ppm_fd_regs.sv -----
// ppm_fd_regs: apb configuration registers of the ppm frame decoder
// depends on ppm_fd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppm_fd_regs (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [ppm_fd_pkg::PaddrW-1:0]    paddr,
  input  wire  [ppm_fd_pkg::PdataW-1:0]    pwdata,
  output logic [ppm_fd_pkg::PdataW-1:0]    prdata,
  output logic                             pready,
  output ppm_fd_pkg::cfg_t                 cfg_o
);

  ppm_fd_pkg::cfg_t     cfg_q;
  ppm_fd_pkg::reg_idx_e sel;
  logic                 wr_en;

  assign pready = 1'b1;
  assign sel    = ppm_fd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gap_min  <= ppm_fd_pkg::SyncGapMinRst;
      cfg_q.pulse_min     <= ppm_fd_pkg::PulseMinRst;
      cfg_q.pulse_max     <= ppm_fd_pkg::PulseMaxRst;
      cfg_q.channel_count <= ppm_fd_pkg::ChanCountRst;
    end else if (wr_en) begin
      case (sel)
        ppm_fd_pkg::REG_SYNC_GAP_MIN: cfg_q.sync_gap_min  <= pwdata[15:0];
        ppm_fd_pkg::REG_PULSE_MIN:    cfg_q.pulse_min     <= pwdata[15:0];
        ppm_fd_pkg::REG_PULSE_MAX:    cfg_q.pulse_max     <= pwdata[15:0];
        ppm_fd_pkg::REG_CHAN_COUNT:   cfg_q.channel_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      ppm_fd_pkg::REG_SYNC_GAP_MIN: prdata = {16'd0, cfg_q.sync_gap_min};
      ppm_fd_pkg::REG_PULSE_MIN:    prdata = {16'd0, cfg_q.pulse_min};
      ppm_fd_pkg::REG_PULSE_MAX:    prdata = {16'd0, cfg_q.pulse_max};
      ppm_fd_pkg::REG_CHAN_COUNT:   prdata = {28'd0, cfg_q.channel_count};
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppm_fd_frame.sv -----
// ppm_fd_frame: input register, interval classification and channel store
// depends on ppm_fd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppm_fd_frame #(
  parameter int unsigned MAX_CHANNELS = 10
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        in_valid_i,
  output logic                                       in_ready_o,
  input  wire  [ppm_fd_pkg::TimeW-1:0]               edge_time_us_i,
  input  wire                                        from_ppm_pin_i,
  input  ppm_fd_pkg::cfg_t                           cfg_i,
  input  wire                                        emit_idle_i,
  output ppm_fd_pkg::burst_ctl_t                     ctl_o,
  output logic [MAX_CHANNELS-1:0][ppm_fd_pkg::DeltaW-1:0] snap_o
);

  localparam int unsigned IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [4:0]  MaxN = 5'(MAX_CHANNELS);

  // input register
  logic                            s1_valid_q;
  logic [ppm_fd_pkg::DeltaW-1:0]   s1_time_q;
  logic                            s1_pin_q;

  // decoder state; only the low half of the timestamp matters
  logic [ppm_fd_pkg::DeltaW-1:0]   prev_q;
  logic                            armed_q;
  logic [ppm_fd_pkg::ChanW-1:0]    next_q;
  logic                            seen_q;
  logic [ppm_fd_pkg::DeltaW-1:0]   store_q [MAX_CHANNELS];

  logic [ppm_fd_pkg::DeltaW-1:0]   delta;
  logic                            is_sync;
  logic                            in_win;
  logic                            take;
  logic [ppm_fd_pkg::ChanW-1:0]    nc;
  logic [4:0]                      flen;
  logic                            frame_done;
  logic                            burst_req;
  logic                            wr_ok;
  logic                            s1_go;

  assign delta   = s1_time_q - prev_q;
  assign is_sync = delta >= cfg_i.sync_gap_min;
  assign in_win  = (delta >= cfg_i.pulse_min) && (delta <= cfg_i.pulse_max);
  assign take    = s1_pin_q && armed_q && !is_sync && in_win;
  assign nc      = next_q + 4'd1;
  assign flen    = ({1'b0, cfg_i.channel_count} > MaxN) ? MaxN
                                                        : {1'b0, cfg_i.channel_count};
  assign frame_done = ({1'b0, nc} >= flen) || ({1'b0, nc} >= MaxN);
  // a wrapped index requests no burst
  assign burst_req  = take && frame_done && (nc != '0);
  assign wr_ok      = {1'b0, next_q} < MaxN;

  // hold an item that completes a frame while the emitter still drains the previous burst
  assign s1_go      = s1_valid_q && !(burst_req && !emit_idle_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  assign ctl_o.start     = s1_go && burst_req;
  assign ctl_o.link_good = seen_q;
  assign ctl_o.len       = nc;

  // burst contents include the channel written by this item
  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (take && wr_ok && (next_q[IdxW-1:0] == IdxW'(i))) begin
        snap_o[i] = delta;
      end else begin
        snap_o[i] = store_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_time_q <= edge_time_us_i[ppm_fd_pkg::DeltaW-1:0];
      s1_pin_q  <= from_ppm_pin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      armed_q <= 1'b0;
      next_q  <= '0;
      seen_q  <= 1'b0;
    end else if (s1_go && s1_pin_q) begin
      prev_q <= s1_time_q;
      if (armed_q) begin
        if (is_sync) begin
          next_q <= '0;
          seen_q <= 1'b1;
        end else if (in_win) begin
          next_q <= frame_done ? '0 : nc;
        end else begin
          armed_q <= 1'b0;
        end
      end else if (is_sync) begin
        armed_q <= 1'b1;
        next_q  <= '0;
        seen_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && take && wr_ok) begin
      store_q[next_q[IdxW-1:0]] <= delta;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppm_fd_emit.sv -----
// ppm_fd_emit: burst buffer and output register of the ppm frame decoder
// depends on ppm_fd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppm_fd_emit #(
  parameter int unsigned MAX_CHANNELS = 10
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  ppm_fd_pkg::burst_ctl_t                     ctl_i,
  input  wire  [MAX_CHANNELS-1:0][ppm_fd_pkg::DeltaW-1:0] snap_i,
  output logic                                       idle_o,
  output logic                                       out_valid_o,
  input  wire                                        out_ready_i,
  output logic [ppm_fd_pkg::ChanW-1:0]               channel_index_o,
  output logic [ppm_fd_pkg::DeltaW-1:0]              pulse_width_us_o,
  output logic                                       link_good_o,
  output logic                                       last_o
);

  localparam int unsigned IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                            busy_q;
  logic [IdxW-1:0]                 idx_q;
  logic [ppm_fd_pkg::ChanW-1:0]    len_q;
  logic                            link_q;
  logic [ppm_fd_pkg::DeltaW-1:0]   buf_q [MAX_CHANNELS];

  logic                            out_valid_q;
  logic [ppm_fd_pkg::ChanW-1:0]    index_q;
  logic [ppm_fd_pkg::DeltaW-1:0]   width_q;
  logic                            olink_q;
  logic                            last_q;

  logic                            out_load;
  logic                            is_last;

  assign idle_o   = !busy_q;
  assign out_load = busy_q && (!out_valid_q || out_ready_i);
  assign is_last  = ({1'b0, ppm_fd_pkg::ChanW'(idx_q)} + 5'd1) == {1'b0, len_q};

  assign out_valid_o      = out_valid_q;
  assign channel_index_o  = index_q;
  assign pulse_width_us_o = width_q;
  assign link_good_o      = olink_q;
  assign last_o           = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (out_load) begin
        idx_q <= idx_q + 1'b1;
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      len_q  <= ctl_i.len;
      link_q <= ctl_i.link_good;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        buf_q[i] <= snap_i[i];
      end
    end
    if (out_load) begin
      index_q <= ppm_fd_pkg::ChanW'(idx_q);
      width_q <= buf_q[idx_q];
      olink_q <= link_q;
      last_q  <= is_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ppm_fd_checker.sv -----
// ppm_fd_checker: port-level assertions for the ppm frame decoder
// depends on ppm_frame_decoder (bound to it at the end of this file)
`timescale 1ns / 1ps
`default_nettype none

module ppm_fd_checker #(
  parameter int unsigned MAX_CHANNELS = 10
) (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [3:0]  channel_index_o,
  input wire [15:0] pulse_width_us_o,
  input wire        link_good_o,
  input wire        last_o,
  input wire        pready
);

  logic [3:0] exp_idx_q;
  logic       in_burst_q;
  logic       link_q;
  logic       out_acc;

  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q  <= '0;
      in_burst_q <= 1'b0;
      link_q     <= 1'b0;
    end else if (out_acc) begin
      exp_idx_q  <= last_o ? 4'd0 : channel_index_o + 4'd1;
      in_burst_q <= !last_o;
      link_q     <= link_good_o;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pulse_width_us_o)
      && $stable(channel_index_o) && $stable(last_o))
    else $error("stalled result changed");

  // channels of a burst come in order from zero
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_index_o == exp_idx_q)
    else $error("channel index out of sequence");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, channel_index_o} < 5'(MAX_CHANNELS))
    else $error("channel index beyond channel store");

  // link flag is fixed across one burst
  a_link_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_burst_q |-> link_good_o == link_q)
    else $error("link flag changed within a burst");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("apb pready low");

endmodule

bind ppm_frame_decoder ppm_fd_checker #(
  .MAX_CHANNELS (MAX_CHANNELS)
) u_ppm_fd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .channel_index_o  (channel_index_o),
  .pulse_width_us_o (pulse_width_us_o),
  .link_good_o      (link_good_o),
  .last_o           (last_o),
  .pready           (pready)
);

`default_nettype wire
